### hdl/lfo_pkg.sv
// Shared types, register codes and the sine table function for the LFO waveform generator.
`timescale 1ns / 1ps

package lfo_pkg;

    // Sizing
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TURNS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY         = 3'd5;

    typedef enum logic [1:0] {
        WAVE_SINE  = 2'd0,
        WAVE_SAW   = 2'd1,
        WAVE_PULSE = 2'd2,
        WAVE_ZERO  = 2'd3
    } wave_t;

    // Configuration seen by every pipeline stage
    typedef struct packed {
        wave_t              waveform;
        logic [23:0]        frequency;     // Q8.16
        logic signed [15:0] amplitude;     // Q4.12
        logic signed [15:0] level_offset;  // Q4.12
        logic [15:0]        phase_turns;   // Q0.16
        logic [15:0]        duty;          // Q0.16
    } cfg_t;

    // Reset values
    localparam wave_t              RST_WAVEFORM     = WAVE_SINE;
    localparam logic [23:0]        RST_FREQUENCY    = 24'd65536;
    localparam logic signed [15:0] RST_AMPLITUDE    = 16'sd2048;
    localparam logic signed [15:0] RST_LEVEL_OFFSET = 16'sd2048;
    localparam logic [15:0]        RST_PHASE_TURNS  = 16'd0;
    localparam logic [15:0]        RST_DUTY         = 16'd32768;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave entry k of a 2^tbits table, Q1.15, from a Taylor series
    // in Q2.30 radians up to x^11. Evaluated at elaboration only.
    function automatic logic [15:0] quarter_entry(input int unsigned k,
                                                  input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] rnd;
        longint      sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end
            else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (64'(sum) + 64'd16384) >> 15;
        return rnd[15:0];
    endfunction

endpackage

### hdl/lfo_phase.sv
// Phase stages: time times frequency, then phase offset, giving the Q0.16 phase.
`timescale 1ns / 1ps

module lfo_phase
    import lfo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic [31:0] time_sample,
    output logic        dn_valid,
    input  logic        dn_ready,
    output logic [15:0] phase
);

    logic        v1_reg;
    logic        v2_reg;
    logic        ld1;
    logic        ld2;
    logic [55:0] prod_full;
    logic [15:0] mul_reg;
    logic [15:0] mul_next;
    logic [15:0] phase_reg;
    logic [15:0] phase_next;

    // Stage load enables: a stage loads when empty or when its item moves on
    assign ld2      = !v2_reg || dn_ready;
    assign ld1      = !v1_reg || ld2;
    assign up_ready = ld1;
    assign dn_valid = v2_reg;
    assign phase    = phase_reg;

    // Stage 1: fractional turns of time times frequency
    always_comb
    begin
        prod_full = 56'(time_sample) * 56'(cfg.frequency);
        mul_next  = prod_full[31:16];
    end

    // Stage 2: add phase offset, wraps modulo one turn
    assign phase_next = mul_reg + cfg.phase_turns;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= up_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && up_valid)
        begin
            mul_reg <= mul_next;
        end
        if (ld2 && v1_reg)
        begin
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Items in the two stages change only by accepted items
    a_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones({v1_reg, v2_reg}) ==
                 $past($countones({v1_reg, v2_reg})) + $past(int'(up_valid && up_ready))
                 - $past(int'(v2_reg && dn_ready)))
        else $error("lfo_phase: item count mismatch");
`endif

endmodule

### hdl/lfo_wave.sv
// Wave stage: quarter-wave sine table read, saw and pulse values from the phase.
`timescale 1ns / 1ps

module lfo_wave
    import lfo_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [15:0]        phase,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic [15:0]        rom_entry,
    output logic               negate,
    output logic signed [16:0] alt_wave
);

    localparam int DEPTH = (1 << TABLE_BITS) + 1;
    localparam int AW    = TABLE_BITS + 1;
    localparam logic [AW-1:0] FULL = {1'b1, {TABLE_BITS{1'b0}}};

    logic                  v_reg;
    logic                  ld;
    logic [15:0]           rom [DEPTH];
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] k;
    logic [AW-1:0]         addr;
    logic [15:0]           rom_reg;
    logic                  negate_reg;
    logic signed [16:0]    alt_reg;
    logic signed [16:0]    alt_next;

    // Constant quarter-wave table, entries 0 to a full quarter inclusive
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        assign rom[i] = quarter_entry(i, TABLE_BITS);
    end

    assign ld        = !v_reg || dn_ready;
    assign up_ready  = ld;
    assign dn_valid  = v_reg;
    assign rom_entry = rom_reg;
    assign negate    = negate_reg;
    assign alt_wave  = alt_reg;

    // Quadrant folding: odd quadrants read the table backward
    always_comb
    begin
        quad = phase[15:14];
        k    = phase[13 -: TABLE_BITS];
        addr = quad[0] ? (FULL - {1'b0, k}) : {1'b0, k};
    end

    // Saw and pulse in Q1.15; pulse at full scale scales to exactly +-amplitude
    always_comb
    begin
        case (cfg.waveform)
            WAVE_SAW:   alt_next = $signed({1'b0, phase}) - 17'sd32768;
            WAVE_PULSE: alt_next = (phase > cfg.duty) ? 17'sd32768 : -17'sd32768;
            default:    alt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ld)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld && up_valid)
        begin
            rom_reg    <= rom[addr];
            negate_reg <= quad[1];
            alt_reg    <= alt_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The stage holds an item only if one came in or it was already holding
    a_wave_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> v_reg == ($past(up_valid && up_ready) ||
                           ($past(v_reg) && !$past(dn_ready))))
        else $error("lfo_wave: item lost or invented");
`endif

endmodule

### hdl/lfo_scale.sv
// Scale stages: wave times amplitude, rounding, offset and saturation to the output.
`timescale 1ns / 1ps

module lfo_scale
    import lfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [15:0]        rom_entry,
    input  logic               negate,
    input  logic signed [16:0] alt_wave,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic signed [15:0] level
);

    logic               v4_reg;
    logic               v5_reg;
    logic               ld4;
    logic               ld5;
    logic signed [16:0] wave;
    logic signed [32:0] prod_reg;
    logic signed [32:0] prod_next;
    logic signed [33:0] rnd;
    logic signed [19:0] sum;
    logic signed [15:0] level_reg;
    logic signed [15:0] level_next;

    assign ld5      = !v5_reg || dn_ready;
    assign ld4      = !v4_reg || ld5;
    assign up_ready = ld4;
    assign dn_valid = v5_reg;
    assign level    = level_reg;

    // Stage 4: signed Q1.15 wave times Q4.12 amplitude
    always_comb
    begin
        if (cfg.waveform == WAVE_SINE)
        begin
            wave = negate ? -$signed({1'b0, rom_entry}) : $signed({1'b0, rom_entry});
        end
        else
        begin
            wave = alt_wave;
        end
        prod_next = wave * cfg.amplitude;
    end

    // Stage 5: round half up at bit 15, add offset, clamp; the zero waveform gives zero
    always_comb
    begin
        rnd = prod_reg + 34'sd16384;
        sum = $signed(rnd[33:15]) + cfg.level_offset;
        if (cfg.waveform == WAVE_ZERO)
        begin
            level_next = '0;
        end
        else if (sum > 20'sd32767)
        begin
            level_next = 16'sh7FFF;
        end
        else if (sum < -20'sd32768)
        begin
            level_next = 16'sh8000;
        end
        else
        begin
            level_next = sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld4)
            begin
                v4_reg <= up_valid;
            end
            if (ld5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && up_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ld5 && v4_reg)
        begin
            level_reg <= level_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Items in the two stages change only by accepted items
    a_scale_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones({v4_reg, v5_reg}) ==
                 $past($countones({v4_reg, v5_reg})) + $past(int'(up_valid && up_ready))
                 - $past(int'(v5_reg && dn_ready)))
        else $error("lfo_scale: item count mismatch");
`endif

endmodule

### hdl/lfo_waveform_generator.sv
// Top level of the LFO waveform generator: configuration registers and the five-stage pipeline.
`timescale 1ns / 1ps

// Stateless low-frequency oscillator. Each time_sample (Q16.16) turns into one level
// (Q4.12): phase = frac(time_sample * frequency) + phase_turns, then a sine from a
// quarter-wave table, a saw or a pulse against duty, scaled by amplitude, offset by
// level_offset and saturated, or zero for the zero waveform. The pipeline has five
// register stages (multiply, phase add, table read, amplitude multiply, round and
// clamp), which an item passes in that order, and one item is taken every cycle while
// the output is drained; each stage holds its item under back-pressure and empty
// stages still fill.
// Write configuration only while no item is in flight.
module lfo_waveform_generator
    import lfo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            time_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     level
);

    cfg_t               cfg_reg;
    logic               ph_valid;
    logic               ph_ready;
    logic [15:0]        phase;
    logic               wv_valid;
    logic               wv_ready;
    logic [15:0]        rom_entry;
    logic               negate;
    logic signed [16:0] alt_wave;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveform     <= RST_WAVEFORM;
            cfg_reg.frequency    <= RST_FREQUENCY;
            cfg_reg.amplitude    <= RST_AMPLITUDE;
            cfg_reg.level_offset <= RST_LEVEL_OFFSET;
            cfg_reg.phase_turns  <= RST_PHASE_TURNS;
            cfg_reg.duty         <= RST_DUTY;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_WAVEFORM:     cfg_reg.waveform     <= wave_t'(cfg_data[1:0]);
                REG_FREQUENCY:    cfg_reg.frequency    <= cfg_data[23:0];
                REG_AMPLITUDE:    cfg_reg.amplitude    <= $signed(cfg_data[15:0]);
                REG_LEVEL_OFFSET: cfg_reg.level_offset <= $signed(cfg_data[15:0]);
                REG_PHASE_TURNS:  cfg_reg.phase_turns  <= cfg_data[15:0];
                REG_DUTY:         cfg_reg.duty         <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Stages 1-2: phase
    lfo_phase u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (in_valid),
        .up_ready    (in_ready),
        .time_sample (time_sample),
        .dn_valid    (ph_valid),
        .dn_ready    (ph_ready),
        .phase       (phase)
    );

    // Stage 3: wave shape
    lfo_wave #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_valid  (ph_valid),
        .up_ready  (ph_ready),
        .phase     (phase),
        .dn_valid  (wv_valid),
        .dn_ready  (wv_ready),
        .rom_entry (rom_entry),
        .negate    (negate),
        .alt_wave  (alt_wave)
    );

    // Stages 4-5: scale, offset, saturate
    lfo_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_valid  (wv_valid),
        .up_ready  (wv_ready),
        .rom_entry (rom_entry),
        .negate    (negate),
        .alt_wave  (alt_wave),
        .dn_valid  (out_valid),
        .dn_ready  (out_ready),
        .level     (level)
    );

`ifndef NO_ASSERTIONS
    // Input is refused only when the whole pipe is full and the output is stalled
    a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && ph_valid && wv_valid))
        else $error("lfo_waveform_generator: input refused with room in the pipe");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the LFO waveform generator: level predictor, scoreboard and drivers.
`timescale 1ns / 1ps

// Holds a copy of the register file, predicts the level of each accepted sample
// and compares results in order against the queue of predicted levels.
class lfo_level_board;
    localparam int TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF;
    localparam int TABLE_TOP  = 1 << TABLE_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    lfo_pkg::wave_t     wave_sel;
    logic [23:0]        freq;
    logic signed [15:0] amp;
    logic signed [15:0] offs;
    logic [15:0]        shift;
    logic [15:0]        duty;

    int                 quarter[0:TABLE_TOP];
    logic signed [15:0] expected_levels[$];
    int                 errors;
    int                 checked;
    int                 per_wave[4];

    function new();
        for (int k = 0; k <= TABLE_TOP; k++) begin
            quarter[k] = quarter_sine(k);
        end
        errors  = 0;
        checked = 0;
        foreach (per_wave[i]) per_wave[i] = 0;
        reset_regs();
    endfunction

    // Q1.15 sine of a quarter-table point, series in Q2.30 radians up to x^11
    function int quarter_sine(int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_BITS;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        return int'((unsigned'(acc) + 64'd16384) >> 15);
    endfunction

    function void reset_regs();
        wave_sel = lfo_pkg::RST_WAVEFORM;
        freq     = lfo_pkg::RST_FREQUENCY;
        amp      = lfo_pkg::RST_AMPLITUDE;
        offs     = lfo_pkg::RST_LEVEL_OFFSET;
        shift    = lfo_pkg::RST_PHASE_TURNS;
        duty     = lfo_pkg::RST_DUTY;
    endfunction

    // Register write: masked to width, unknown indexes dropped
    function void set_reg(logic [lfo_pkg::CFG_INDEX_W-1:0] index,
                          logic [lfo_pkg::CFG_DATA_W-1:0] data);
        case (index)
            lfo_pkg::REG_WAVEFORM:     wave_sel = lfo_pkg::wave_t'(data[1:0]);
            lfo_pkg::REG_FREQUENCY:    freq     = data[23:0];
            lfo_pkg::REG_AMPLITUDE:    amp      = data[15:0];
            lfo_pkg::REG_LEVEL_OFFSET: offs     = data[15:0];
            lfo_pkg::REG_PHASE_TURNS:  shift    = data[15:0];
            lfo_pkg::REG_DUTY:         duty     = data[15:0];
            default: ;
        endcase
    endfunction

    // Q4.12 level for one Q16.16 time sample
    function logic signed [15:0] level_for(logic [31:0] t);
        logic [55:0] prod;
        logic [15:0] p;
        int          k;
        int          wave;
        longint      lvl;
        prod = 56'(t) * 56'(freq);
        p    = prod[31:16] + shift;
        case (wave_sel)
            lfo_pkg::WAVE_SINE: begin
                k    = int'(p[13:0] >> (14 - TABLE_BITS));
                wave = p[14] ? quarter[TABLE_TOP - k] : quarter[k];
                if (p[15]) wave = -wave;
                lvl  = ((longint'(wave) * longint'(amp)) + 16384) >>> 15;
                lvl  = lvl + longint'(offs);
            end
            lfo_pkg::WAVE_SAW: begin
                lvl = (((longint'(p) - 32768) * longint'(amp)) + 16384) >>> 15;
                lvl = lvl + longint'(offs);
            end
            lfo_pkg::WAVE_PULSE: begin
                // phase equal to duty stays on the low side
                lvl = (p > duty) ? longint'(amp) : -longint'(amp);
                lvl = lvl + longint'(offs);
            end
            default: lvl = 0;
        endcase
        if (lvl > 32767)  lvl = 32767;
        if (lvl < -32768) lvl = -32768;
        return lvl[15:0];
    endfunction

    function void note_sample(logic [31:0] t);
        expected_levels.push_back(level_for(t));
        per_wave[wave_sel]++;
    endfunction

    function void check_level(logic signed [15:0] seen);
        logic signed [15:0] want;
        if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: level %0d arrived with no sample pending", $time, seen);
            return;
        end
        want = expected_levels.pop_front();
        checked++;
        if (seen !== want) begin
            errors++;
            $display("%0t: level expected %0d actual %0d", $time, want, seen);
        end
    endfunction

    function int pending();
        return expected_levels.size();
    endfunction
endclass

module tb_top;
    import lfo_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 900;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [31:0]            time_sample;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [15:0]     level;

    lfo_level_board levels;
    int  cycle_count   = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    int  sent          = 0;
    int  settings_seen = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;

    lfo_waveform_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .time_sample  (time_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level        (level)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d levels still due",
                     cycle_count, levels.pending());
            $display("lfo_waveform_generator: mismatch");
            $finish;
        end
    end

    // Output side: check accepted levels, random stalls, long hold on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            levels.check_level(level);
        end
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= 13);
        end
    end

    // Offer one sample and hold it until taken; maybe idle afterwards
    task automatic send_sample(input logic [31:0] t);
        in_valid    <= 1'b1;
        time_sample <= t;
        do @(posedge clk); while (!in_ready);
        levels.note_sample(t);
        sent++;
        if (!tx_steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted level has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (levels.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        levels.set_reg(idx, data);
    endtask

    // Write the whole register file once the pipeline is empty
    task automatic apply_settings(input bit with_spare,
                                  input logic [23:0] w, f, a, o, ph, d);
        drain_results();
        if (with_spare)
        begin
            write_reg(REG_SPARE_A, 24'hFFFFFF);
            write_reg(REG_SPARE_B, 24'hA5A5A5);
        end
        write_reg(REG_WAVEFORM, w);
        write_reg(REG_FREQUENCY, f);
        write_reg(REG_AMPLITUDE, a);
        write_reg(REG_LEVEL_OFFSET, o);
        write_reg(REG_PHASE_TURNS, ph);
        write_reg(REG_DUTY, d);
        cfg_write_en <= 1'b0;
        settings_seen++;
    endtask

    // Random register values, corners mixed in, junk in the unused high bits
    function automatic logic [23:0] rand_wave();
        return {22'($urandom), 2'($urandom_range(0, 3))};
    endfunction

    function automatic logic [23:0] rand_freq();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h010000;
            3, 4:    return 24'($urandom_range(1, 24'h03FFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_q12();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'h0000;
            3:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return {8'($urandom), v};
    endfunction

    function automatic logic [23:0] rand_turns();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h8000;
            default: v = 16'($urandom);
        endcase
        return {8'($urandom), v};
    endfunction

    // Mostly uniform samples; at unit frequency sometimes land the phase on duty
    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'hFFFFFFFF;
        if (r == 1) return 32'h00000000;
        if (r <= 4 && levels.freq == 24'h010000)
            return {16'($urandom), 16'(levels.duty - levels.shift)};
        return $urandom;
    endfunction

    initial
    begin
        logic [31:0] reset_points[7];
        int          total;
        int          rand_phase;
        reset_points = '{32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
                         32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_2000};
        levels       = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_WAVEFORM;
        cfg_data     = '0;
        in_valid     = 1'b0;
        time_sample  = '0;
        out_ready    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sine across the quadrant edges
        foreach (reset_points[i]) send_sample(reset_points[i]);

        // Saw at full scale with high offset, masked writes, dropped spare writes
        apply_settings(1'b1, 24'hFFFFFD, 24'h010000, 24'hAB7FFF, 24'h127FFF,
                       24'h000000, 24'h008000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0000_8000);
        send_sample(32'hFFFF_FFFF);

        // Pulse at most negative swing: phase on duty, just above, below
        apply_settings(1'b0, {22'd0, WAVE_PULSE}, 24'h010000, 24'h008000, 24'h008000,
                       24'h001234, 24'h004000);
        send_sample(32'h0000_2DCC);
        send_sample(32'h0000_2DCD);
        send_sample(32'h0000_0000);

        // Zero waveform ignores the offset
        apply_settings(1'b0, {22'd0, WAVE_ZERO}, 24'hFFFFFF, 24'h007FFF, 24'h0003E8,
                       24'h00FFFF, 24'h00FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h1234_5678);

        // Sine at top frequency and full swing, lowest offset
        apply_settings(1'b0, {22'd0, WAVE_SINE}, 24'hFFFFFF, 24'h007FFF, 24'h008000,
                       24'h00FFFF, 24'h000000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'h0003_FFFF);

        // Frozen phase sitting exactly on duty, at both ends of the range
        apply_settings(1'b0, {22'd0, WAVE_PULSE}, 24'h000000, 24'h007FFF, 24'h000000,
                       24'h00FFFF, 24'h00FFFF);
        send_sample(32'hDEAD_BEEF);
        apply_settings(1'b0, {22'd0, WAVE_PULSE}, 24'h000000, 24'h007FFF, 24'h000000,
                       24'h000000, 24'h000000);
        send_sample(32'h5555_AAAA);

        // Random settings, each held for a burst of random samples
        total      = sent + RANDOM_ITEMS;
        rand_phase = 0;
        while (sent < total)
        begin
            apply_settings(1'b0, rand_wave(), rand_freq(), rand_q12(), rand_q12(),
                           rand_turns(), rand_turns());
            tx_steady = (rand_phase == 3);
            rx_steady = (rand_phase == 3);
            if (rand_phase == 5)
            begin
                // output blocked for a long while, input keeps pushing
                hold_requests++;
                tx_steady = 1'b1;
            end
            repeat ($urandom_range(30, 70)) send_sample(pick_sample());
            rand_phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        $display("run covered %0d samples over %0d register settings", sent, settings_seen);
        $display("by waveform sine/saw/pulse/zero: %0d/%0d/%0d/%0d, %0d levels checked",
                 levels.per_wave[0], levels.per_wave[1], levels.per_wave[2],
                 levels.per_wave[3], levels.checked);
        if (levels.errors == 0)
        begin
            $display("lfo_waveform_generator: match");
        end
        else
        begin
            $display("lfo_waveform_generator: mismatch");
        end
        $finish;
    end

endmodule

### lfo_waveform_generator.f
hdl/lfo_pkg.sv
hdl/lfo_phase.sv
hdl/lfo_wave.sv
hdl/lfo_scale.sv
hdl/lfo_waveform_generator.sv
tb/sv/tb_top.sv
